// ===== hdl/dpht_pkg.sv =====
`timescale 1ns / 1ps
package dpht_pkg;
    localparam int MaxRecords  = 4096;
    localparam int BucketCount = 8192;
    localparam int SlotW       = $clog2(MaxRecords);
    localparam int CountW      = SlotW + 1;
    localparam int BucketW     = $clog2(BucketCount);

    typedef enum logic [1:0] {
        OP_UPSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_ROTATE = 2'd2,
        OP_COUNT  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_UPDATED   = 3'd0,
        ST_INSERTED  = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_DONE      = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_HEAD_RD,
        S_HEAD_WAIT,
        S_CHAIN_RD,
        S_CHAIN_WAIT,
        S_CHAIN_CMP,
        S_REC_WAIT,
        S_REC_OUT,
        S_SWEEP_RD,
        S_SWEEP_WAIT,
        S_SWEEP_DO,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [7:0]  count;
        logic [7:0]  flags;
        logic [7:0]  source;
        logic [31:0] first;
        logic [31:0] last;
    } record_t;

    function automatic logic [BucketW-1:0] bucket_of(input logic [47:0] id);
        logic [23:0] folded;
        folded = id[47:24] ^ id[23:0];
        return folded[BucketW-1:0];
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = '0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction
endpackage

// ===== hdl/dpht_ram.sv =====
`timescale 1ns / 1ps
module dpht_ram #(
    parameter int Depth = 4096,
    parameter int Width = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/device_presence_hash_table.sv =====
`timescale 1ns / 1ps
// Hash table of 48-bit device IDs with chained buckets; one transaction at a time,
// busy is high while it runs and the result appears for one cycle with done, in the
// first cycle after busy falls.
// After reset a clearing pass over all 8192 bucket heads empties them (busy high).
// Upsert and lookup read the bucket head, walk its chain one entry at a time and then
// read or write the record; rotate and count visit each record in use in turn, rotate
// shifting its presence flags right and count tallying those with enough flags set.
// Results cannot be held off by the receiver.
module device_presence_hash_table
    import dpht_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         op,
    input  logic [47:0]        dev_id,
    input  logic [7:0]         source_kind,
    input  logic [31:0]        now_seconds,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_wdata,
    output logic               done,
    output logic [2:0]         status,
    output logic [11:0]        slot,
    output logic [7:0]         seen_count,
    output logic [7:0]         presence_flags,
    output logic [7:0]         record_source,
    output logic [31:0]        first_time,
    output logic [31:0]        last_time,
    output logic [12:0]        suspicious_total,
    output logic [12:0]        records_in_use
);
    state_t state_reg, state_next;
    logic [3:0]         thr_reg;
    logic [1:0]         op_reg;
    logic [47:0]        id_reg;
    logic [7:0]         src_reg;
    logic [31:0]        now_reg;
    logic [CountW-1:0]  used_reg, used_next;
    logic [CountW-1:0]  steps_reg, steps_next;
    logic [CountW-1:0]  total_reg, total_next;
    logic [CountW-1:0]  idx_reg, idx_next;   // current record (or sweep index)
    logic [BucketW-1:0] clr_reg, clr_next;
    logic [2:0]         status_reg, status_next;
    logic               hit_reg, hit_next;
    logic               done_reg;

    // Bucket head memory: bit above the index is the valid flag.
    logic               head_we;
    logic [BucketW-1:0] head_waddr, head_raddr;
    logic [SlotW:0]     head_wdata, head_rdata;
    // Chain memory: {link valid, link, id}.
    logic               chain_we;
    logic [SlotW-1:0]   chain_waddr, chain_raddr;
    logic [SlotW+48:0]  chain_wdata, chain_rdata;
    // Record payload memory.
    logic               rec_we;
    logic [SlotW-1:0]   rec_waddr, rec_raddr;
    record_t            rec_wdata, rec_rdata;

    dpht_ram #(.Depth(BucketCount), .Width(SlotW + 1)) u_heads (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata));
    dpht_ram #(.Depth(MaxRecords), .Width(SlotW + 49)) u_chain (
        .clk(clk), .we(chain_we), .waddr(chain_waddr), .wdata(chain_wdata),
        .raddr(chain_raddr), .rdata(chain_rdata));
    dpht_ram #(.Depth(MaxRecords), .Width($bits(record_t))) u_rec (
        .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
        .raddr(rec_raddr), .rdata(rec_rdata));

    logic [BucketW-1:0] bkt;
    assign bkt = bucket_of(id_reg);

    record_t     upd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            thr_reg   <= 4'd2;
            used_reg  <= '0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            clr_reg   <= clr_next;
            done_reg  <= (state_next == S_IDLE) && (state_reg != S_IDLE)
                         && (state_reg != S_CLEAR);
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
        end
    end

    assign done = done_reg;

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            op_reg  <= op;
            id_reg  <= dev_id;
            src_reg <= source_kind;
            now_reg <= now_seconds;
        end
        steps_reg  <= steps_next;
        total_reg  <= total_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        used_next   = used_reg;
        steps_next  = steps_reg;
        total_next  = total_reg;
        idx_next    = idx_reg;
        clr_next    = clr_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        head_we     = 1'b0;
        head_waddr  = clr_reg;
        head_wdata  = '0;
        head_raddr  = bkt;
        chain_we    = 1'b0;
        chain_waddr = used_reg[SlotW-1:0];
        chain_wdata = {head_rdata, id_reg};
        chain_raddr = idx_reg[SlotW-1:0];
        rec_we      = 1'b0;
        rec_waddr   = idx_reg[SlotW-1:0];
        rec_raddr   = idx_reg[SlotW-1:0];
        upd         = rec_rdata;
        rec_wdata   = rec_rdata;
        unique case (state_reg)
            S_CLEAR:
            begin
                head_we  = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == BucketW'(BucketCount - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                hit_next   = 1'b0;
                total_next = '0;
                idx_next   = '0;
                steps_next = '0;
                if (start)
                begin
                    if (op == OP_ROTATE || op == OP_COUNT)
                    begin
                        state_next = S_SWEEP_RD;
                    end
                    else
                    begin
                        state_next = S_HEAD_RD;
                    end
                end
            end
            S_HEAD_RD:
            begin
                state_next = S_HEAD_WAIT;
            end
            S_HEAD_WAIT:
            begin
                idx_next = {1'b0, head_rdata[SlotW-1:0]};
                if (head_rdata[SlotW] && ({1'b0, head_rdata[SlotW-1:0]} < used_reg))
                begin
                    state_next = S_CHAIN_RD;
                end
                else
                begin
                    state_next = S_CHAIN_CMP;
                end
                hit_next = 1'b0;
            end
            S_CHAIN_RD:
            begin
                state_next = S_CHAIN_WAIT;
            end
            S_CHAIN_WAIT:
            begin
                state_next = S_CHAIN_CMP;
                steps_next = steps_reg + 1'b1;
                if (chain_rdata[47:0] == id_reg)
                begin
                    hit_next = 1'b1;
                end
                else if (chain_rdata[SlotW+48] &&
                         ({1'b0, chain_rdata[SlotW+47:48]} < used_reg) &&
                         (steps_reg + 1'b1 < used_reg))
                begin
                    idx_next   = {1'b0, chain_rdata[SlotW+47:48]};
                    state_next = S_CHAIN_RD;
                end
            end
            S_CHAIN_CMP:
            begin
                // Chain walk finished; decide the outcome.
                if (hit_reg)
                begin
                    state_next = S_REC_WAIT;
                end
                else if (op_reg == OP_LOOKUP)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_FINISH;
                end
                else if (used_reg >= CountW'(MaxRecords))
                begin
                    status_next = ST_FULL;
                    state_next  = S_FINISH;
                end
                else
                begin
                    // Head read is still valid: the head memory keeps reading bkt.
                    head_raddr  = bkt;
                    state_next  = S_REC_OUT;
                    status_next = ST_INSERTED;
                    idx_next    = used_reg;
                end
            end
            S_REC_WAIT:
            begin
                state_next = S_REC_OUT;
                status_next = (op_reg == OP_LOOKUP) ? ST_FOUND : ST_UPDATED;
            end
            S_REC_OUT:
            begin
                state_next = S_FINISH;
                if (status_reg == ST_INSERTED)
                begin
                    chain_we   = 1'b1;
                    head_we    = 1'b1;
                    head_waddr = bkt;
                    head_wdata = {1'b1, used_reg[SlotW-1:0]};
                    rec_we     = 1'b1;
                    rec_wdata  = '{count: 8'd1, flags: 8'h01, source: src_reg,
                                   first: now_reg, last: now_reg};
                    used_next  = used_reg + 1'b1;
                end
                else if (status_reg == ST_UPDATED)
                begin
                    upd.count = (rec_rdata.count == 8'hFF) ? 8'hFF
                                : rec_rdata.count + 8'd1;
                    upd.flags = rec_rdata.flags | 8'h01;
                    rec_we    = 1'b1;
                    rec_wdata = upd;
                end
            end
            S_SWEEP_RD:
            begin
                if (idx_reg >= used_reg)
                begin
                    status_next = ST_DONE;
                    state_next  = S_FINISH;
                end
                else
                begin
                    state_next = S_SWEEP_WAIT;
                end
            end
            S_SWEEP_WAIT:
            begin
                state_next = S_SWEEP_DO;
            end
            S_SWEEP_DO:
            begin
                if (op_reg == OP_ROTATE)
                begin
                    upd.flags = rec_rdata.flags >> 1;
                    rec_we    = 1'b1;
                    rec_wdata = upd;
                end
                else if (popcount8(rec_rdata.flags) >= thr_reg)
                begin
                    total_next = total_reg + 1'b1;
                end
                idx_next   = idx_reg + 1'b1;
                state_next = S_SWEEP_RD;
            end
            S_FINISH:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result registers, loaded as the transaction leaves S_FINISH (the record in S_REC_OUT).
    logic [2:0]  status_out_reg;
    logic [11:0] slot_reg;
    record_t     rec_out_reg;
    logic [12:0] total_out_reg, used_out_reg;
    logic        rec_ok;

    assign rec_ok = (status_reg == ST_UPDATED) || (status_reg == ST_INSERTED)
                    || (status_reg == ST_FOUND);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_REC_OUT)
        begin
            rec_out_reg <= (status_reg == ST_FOUND) ? rec_rdata : rec_wdata;
        end
        if (state_reg == S_FINISH)
        begin
            status_out_reg <= status_reg;
            slot_reg       <= rec_ok ? 12'(idx_reg) : 12'd0;
            total_out_reg  <= (op_reg == OP_COUNT) ? 13'(total_reg) : 13'd0;
            used_out_reg   <= 13'(used_reg);
            if (!rec_ok)
            begin
                rec_out_reg <= '0;
            end
        end
    end

    assign status           = status_out_reg;
    assign slot             = slot_reg;
    assign seen_count       = rec_out_reg.count;
    assign presence_flags   = rec_out_reg.flags;
    assign record_source    = rec_out_reg.source;
    assign first_time       = rec_out_reg.first;
    assign last_time        = rec_out_reg.last;
    assign suspicious_total = total_out_reg;
    assign records_in_use   = used_out_reg;

`ifndef SYNTHESIS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CountW'(MaxRecords)) else $error("record count overflow");
    a_used_step: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg != $past(used_reg) |-> $past(state_reg) == S_REC_OUT)
        else $error("record count moved outside insert");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= used_reg || state_reg == S_IDLE || state_reg == S_CLEAR)
        else $error("total too big");
`endif
endmodule
